// ===== rtl/lsh_pkg.sv =====
// lsh_pkg: shared types and constants of the latency statistics histogram
// used by lsh_front, lsh_bins, lsh_fifo and the top level; no dependencies
package lsh_pkg;

    localparam int LSH_BIN_COUNT  = 1024;
    localparam int LSH_BIN_AW     = $clog2(LSH_BIN_COUNT);
    localparam int LSH_BIN_W      = 16;
    localparam logic [31:0] LSH_MIN_RESET = 32'd10000;

    // result queue behind the histogram pipeline
    localparam int LSH_FIFO_DEPTH = 4;
    localparam int LSH_FIFO_AW    = $clog2(LSH_FIFO_DEPTH);
    localparam int LSH_FIFO_CW    = $clog2(LSH_FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_END    = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [31:0] late_count;
        logic [63:0] delta_sum;
        logic [31:0] max_delta;
        logic [31:0] min_delta;
        logic [31:0] sample_count;
    } t_stats;

    // one histogram operation handed from the front to the bin unit
    typedef struct packed {
        t_kind                   kind;
        logic                    in_range;
        logic                    late;
        logic [LSH_BIN_AW-1:0]   addr;
        t_stats                  stats;
    } t_bin_op;

    typedef struct packed {
        t_stats                  stats;
        logic [LSH_BIN_W-1:0]    bin_value;
    } t_result;

endpackage

// ===== rtl/lsh_ram.sv =====
// lsh_ram: generic single write port, single read port ram with registered read
// no dependencies
module lsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lsh_front.sv =====
// lsh_front: accepts items, keeps the window statistics and issues bin operations
// depends on lsh_pkg
module lsh_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  lsh_pkg::t_kind          i_kind,
    input  logic [31:0]             i_delta,
    input  logic [9:0]              i_bin_index,
    output logic                    o_op_valid,
    output lsh_pkg::t_bin_op        o_op
);

    logic [31:0]        r_min;
    logic [31:0]        r_max;
    logic [63:0]        r_sum;
    logic [31:0]        r_count;
    logic [31:0]        r_late;
    logic [31:0]        n_min;
    logic [31:0]        n_max;
    logic [63:0]        n_sum;
    logic [31:0]        n_count;
    logic [31:0]        n_late;
    logic               r_op_valid;
    lsh_pkg::t_bin_op   r_op;
    lsh_pkg::t_bin_op   n_op;
    logic [31:0]        w_idx32;
    logic               w_late;

    assign w_idx32 = 32'(i_bin_index);

    always_comb begin
        n_min   = r_min;
        n_max   = r_max;
        n_sum   = r_sum;
        n_count = r_count;
        n_late  = r_late;
        w_late  = 1'b0;
        n_op.kind     = i_kind;
        n_op.in_range = 1'b0;
        n_op.late     = 1'b0;
        n_op.addr     = w_idx32[lsh_pkg::LSH_BIN_AW-1:0];
        n_op.stats    = '{late_count: r_late, delta_sum: r_sum, max_delta: r_max,
                          min_delta: r_min, sample_count: r_count};
        case (i_kind)
            lsh_pkg::KIND_SAMPLE: begin
                n_max   = (i_delta > r_max) ? i_delta : r_max;
                n_min   = (i_delta < r_min) ? i_delta : r_min;
                n_sum   = r_sum + 64'(i_delta);
                n_count = r_count + 32'd1;
                w_late  = i_delta > n_min;
                n_late  = r_late + 32'(w_late);
                n_op.late     = w_late;
                n_op.in_range = i_delta < 32'(lsh_pkg::LSH_BIN_COUNT);
                n_op.addr     = i_delta[lsh_pkg::LSH_BIN_AW-1:0];
                n_op.stats    = '{late_count: n_late, delta_sum: n_sum, max_delta: n_max,
                                  min_delta: n_min, sample_count: n_count};
            end
            lsh_pkg::KIND_READ: begin
                n_op.in_range = w_idx32 < 32'(lsh_pkg::LSH_BIN_COUNT);
            end
            lsh_pkg::KIND_END: begin
                // result carries the old window, minimum carries over from the maximum
                n_min   = r_max;
                n_max   = '0;
                n_sum   = '0;
                n_count = '0;
                n_late  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= lsh_pkg::LSH_MIN_RESET;
            r_max      <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_late     <= '0;
            r_op_valid <= 1'b0;
        end else begin
            r_op_valid <= i_accept;
            if (i_accept) begin
                r_min   <= n_min;
                r_max   <= n_max;
                r_sum   <= n_sum;
                r_count <= n_count;
                r_late  <= n_late;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op <= n_op;
        end
    end

    assign o_op_valid = r_op_valid;
    assign o_op       = r_op;

endmodule

// ===== rtl/lsh_bins.sv =====
// lsh_bins: histogram read-modify-write pipeline with clearing pass after reset
// depends on lsh_pkg and lsh_ram
module lsh_bins (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_op_valid,
    input  lsh_pkg::t_bin_op        i_op,
    output logic                    o_busy,
    output logic                    o_res_valid,
    output lsh_pkg::t_result        o_res
);

    localparam int AW = lsh_pkg::LSH_BIN_AW;
    localparam int BW = lsh_pkg::LSH_BIN_W;

    logic               r_clearing;
    logic [AW-1:0]      r_clr_addr;
    logic               r_s2_valid;
    lsh_pkg::t_bin_op   r_s2;
    logic               r_lw_valid;
    logic [AW-1:0]      r_lw_addr;
    logic [BW-1:0]      r_lw_data;
    logic [BW-1:0]      w_rdata;
    logic [BW-1:0]      w_cur;
    logic               w_inc;
    logic               w_clr;
    logic               w_we;
    logic [BW-1:0]      w_wdata;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BW-1:0]      ram_wdata;

    lsh_ram #(
        .WIDTH (BW),
        .DEPTH (lsh_pkg::LSH_BIN_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_op.addr),
        .o_rdata (w_rdata)
    );

    // the write that landed on the same edge as this read is not in the ram data
    assign w_cur = (r_lw_valid && (r_lw_addr == r_s2.addr)) ? r_lw_data : w_rdata;

    assign w_inc   = r_s2_valid && (r_s2.kind == lsh_pkg::KIND_SAMPLE)
                     && r_s2.late && r_s2.in_range;
    assign w_clr   = r_s2_valid && (r_s2.kind == lsh_pkg::KIND_READ) && r_s2.in_range;
    assign w_we    = w_inc || w_clr;
    assign w_wdata = w_inc ? (w_cur + BW'(1)) : '0;

    assign ram_we    = r_clearing || w_we;
    assign ram_waddr = r_clearing ? r_clr_addr : r_s2.addr;
    assign ram_wdata = r_clearing ? '0 : w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s2_valid <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(lsh_pkg::LSH_BIN_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s2_valid <= i_op_valid;
            r_lw_valid <= w_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2      <= i_op;
        r_lw_addr <= r_s2.addr;
        r_lw_data <= w_wdata;
    end

    assign o_busy          = r_clearing;
    assign o_res_valid     = r_s2_valid;
    assign o_res.stats     = r_s2.stats;
    assign o_res.bin_value = w_clr ? w_cur : '0;

endmodule

// ===== rtl/lsh_fifo.sv =====
// lsh_fifo: short result queue that decouples the bin pipeline from the output
// depends on lsh_pkg
module lsh_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  lsh_pkg::t_result                i_data,
    input  logic                            i_ready,
    output logic                            o_valid,
    output lsh_pkg::t_result                o_data,
    output logic [lsh_pkg::LSH_FIFO_CW-1:0] o_count
);

    localparam int AW = lsh_pkg::LSH_FIFO_AW;
    localparam int CW = lsh_pkg::LSH_FIFO_CW;

    lsh_pkg::t_result   r_mem [lsh_pkg::LSH_FIFO_DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;
    logic               w_pop;

    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== rtl/latency_stats_histogram.sv =====
// latency_stats_histogram: top level of the latency monitor
// depends on lsh_pkg, lsh_front, lsh_bins and lsh_fifo
//
// Latency monitor with a 1024-bin histogram of late samples. It takes one beat
// per cycle while s_axis_tready is high: sample (tuser 0), read-and-clear bin (1),
// end window (2). Every beat yields exactly one result beat carrying sample count,
// minimum, maximum, 64-bit sum, late count and the bin value of a read. A result
// passes the front register and the bin stage, where the histogram read-modify-write
// goes through the registered-read bin ram; results wait in a four-entry queue, and
// input is held off once the queue entries and the beats in the two pipeline stages
// add up to four. After reset the bin ram is zeroed one entry per cycle, so
// s_axis_tready stays low until all 1024 bins are cleared.
module latency_stats_histogram (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,   // delta[31:0], bin_index[41:32], zero fill
    input  logic [1:0]    s_axis_tuser,   // kind[1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [207:0]  m_axis_tdata    // sample_count[31:0], min_delta[63:32],
                                          // max_delta[95:64], delta_sum[159:96],
                                          // late_count[191:160], bin_value[207:192]
);

    localparam int CW = lsh_pkg::LSH_FIFO_CW;

    logic                   w_accept;
    logic                   op_valid;
    lsh_pkg::t_bin_op       op;
    logic                   bins_busy;
    logic                   res_valid;
    lsh_pkg::t_result       res;
    logic                   out_valid;
    lsh_pkg::t_result       out_data;
    logic [CW-1:0]          fifo_count;
    logic [CW-1:0]          w_used;

    // queue entries plus beats still in the two pipeline stages
    assign w_used        = fifo_count + CW'(op_valid) + CW'(res_valid);
    assign s_axis_tready = !bins_busy && (w_used < CW'(lsh_pkg::LSH_FIFO_DEPTH));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    lsh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_kind      (lsh_pkg::t_kind'(s_axis_tuser)),
        .i_delta     (s_axis_tdata[31:0]),
        .i_bin_index (s_axis_tdata[41:32]),
        .o_op_valid  (op_valid),
        .o_op        (op)
    );

    lsh_bins u_bins (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .o_busy      (bins_busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lsh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_ready (m_axis_tready),
        .o_valid (out_valid),
        .o_data  (out_data),
        .o_count (fifo_count)
    );

    assign m_axis_tvalid          = out_valid;
    assign m_axis_tdata[31:0]     = out_data.stats.sample_count;
    assign m_axis_tdata[63:32]    = out_data.stats.min_delta;
    assign m_axis_tdata[95:64]    = out_data.stats.max_delta;
    assign m_axis_tdata[159:96]   = out_data.stats.delta_sum;
    assign m_axis_tdata[191:160]  = out_data.stats.late_count;
    assign m_axis_tdata[207:192]  = out_data.bin_value;

endmodule
